[rtl/nsc_pkg.sv]
// Shared types and constants of the NMEA sentence checker.
`default_nettype none

package nsc_pkg;

    // Characters the checker looks for
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Shortest line that can hold a valid sentence
    localparam int MIN_LINE_LEN = 7;

    // Widths of the stream payloads
    localparam int IN_DATA_W  = 8;
    localparam int LINE_LEN_W = 10;
    localparam int OUT_DATA_W = 24;

    // Running per-line state apart from the character count
    typedef struct packed {
        logic [7:0] running_xor;
        logic [7:0] xor_at_last_star;
        logic       star_seen;
        logic [1:0] chars_after_star;
        logic [7:0] given_high_char;
        logic [7:0] given_low_char;
        logic       first_is_dollar;
        logic       held_carriage_return;
    } t_line_state;

    // Verdict for one closed line
    typedef struct packed {
        logic                  starts_with_dollar;
        logic                  has_star;
        logic [LINE_LEN_W-1:0] line_length;
        logic [7:0]            computed_checksum;
        logic                  sentence_valid;
    } t_verdict;

endpackage

`default_nettype wire

[rtl/nsc_line_tracker.sv]
// Per-line state registers, updated once for every received byte.
`default_nettype none

module nsc_line_tracker #(
    parameter int MAX_LINE_COUNT = 1023,
    parameter int CNT_W          = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [7:0]         i_byte,
    output nsc_pkg::t_line_state    o_state,
    output logic      [CNT_W-1:0]   o_count,
    output logic                    o_emit
);

    typedef struct packed {
        nsc_pkg::t_line_state s;
        logic [CNT_W-1:0]     cnt;
    } t_track;

    t_track r_track;
    t_track n_track;

    // Fold one data character into the line state
    function automatic t_track take_char(input t_track f, input logic [7:0] c);
        t_track r;
        r = f;
        if (f.cnt == '0) begin
            r.s.first_is_dollar = (c == nsc_pkg::CHAR_DOLLAR);
        end
        if (c == nsc_pkg::CHAR_STAR) begin
            r.s.star_seen        = 1'b1;
            r.s.xor_at_last_star = f.s.running_xor;
            r.s.chars_after_star = 2'd0;
        end else if (f.s.star_seen && (f.s.chars_after_star < 2'd2)) begin
            if (f.s.chars_after_star == 2'd0) begin
                r.s.given_high_char = c;
            end else begin
                r.s.given_low_char = c;
            end
            r.s.chars_after_star = f.s.chars_after_star + 2'd1;
        end
        if (f.cnt != '0) begin
            r.s.running_xor = f.s.running_xor ^ c;
        end
        if (f.cnt < CNT_W'(MAX_LINE_COUNT)) begin
            r.cnt = f.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    // Next state: clear at line feed, else release any held CR and take the byte
    always_comb begin
        n_track = r_track;
        if (i_en) begin
            if (i_byte == nsc_pkg::CHAR_LF) begin
                n_track = '0;
            end else begin
                if (r_track.s.held_carriage_return) begin
                    n_track = take_char(n_track, nsc_pkg::CHAR_CR);
                    n_track.s.held_carriage_return = 1'b0;
                end
                if (i_byte == nsc_pkg::CHAR_CR) begin
                    n_track.s.held_carriage_return = 1'b1;
                end else begin
                    n_track = take_char(n_track, i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
        end else begin
            r_track <= n_track;
        end
    end

    // A line feed closing a non-empty line yields a verdict
    assign o_emit  = i_en && (i_byte == nsc_pkg::CHAR_LF) && (r_track.cnt != '0);
    assign o_state = r_track.s;
    assign o_count = r_track.cnt;

endmodule

`default_nettype wire

[rtl/nsc_verdict.sv]
// Checksum comparison and line checks that form the verdict of a closed line.
`default_nettype none

module nsc_verdict #(
    parameter int CNT_W = 10
) (
    input  wire nsc_pkg::t_line_state   i_state,
    input  wire logic [CNT_W-1:0]       i_count,
    output nsc_pkg::t_verdict           o_verdict
);

    localparam int EXT_W = CNT_W + nsc_pkg::LINE_LEN_W;

    logic [7:0]       sum;
    logic [4:0]       hi_val;
    logic [4:0]       lo_val;
    logic [EXT_W-1:0] count_ext;

    // Hex digit value, 16 for anything that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

    assign sum       = i_state.star_seen ? i_state.xor_at_last_star : 8'h00;
    assign hi_val    = hex_value(i_state.given_high_char);
    assign lo_val    = hex_value(i_state.given_low_char);
    assign count_ext = {{nsc_pkg::LINE_LEN_W{1'b0}}, i_count};

    // Combine the checks
    always_comb begin
        o_verdict.sentence_valid     = (i_count >= CNT_W'(nsc_pkg::MIN_LINE_LEN))
                                       && i_state.first_is_dollar
                                       && i_state.star_seen
                                       && (i_state.chars_after_star >= 2'd2)
                                       && (hi_val == {1'b0, sum[7:4]})
                                       && (lo_val == {1'b0, sum[3:0]});
        o_verdict.computed_checksum  = sum;
        o_verdict.line_length        = count_ext[nsc_pkg::LINE_LEN_W-1:0];
        o_verdict.has_star           = i_state.star_seen;
        o_verdict.starts_with_dollar = i_state.first_is_dollar;
    end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// Top level of the NMEA sentence checker: input register, line tracker, verdict logic, result register.
//
// Takes one received byte per clock cycle, splits the stream into lines at
// line feed and, for every non-empty line, presents one verdict item on the
// output once the closing line feed has passed the input register and its
// verdict has been captured in the result register: sentence_valid, the XOR
// checksum between byte 0 and the last '*', the line length, and the star and
// dollar flags. Bytes that do not close a line give no item. The rate of one
// byte per cycle is set by the single register set of the line tracker, which
// folds each byte (and a held carriage return) in a single update. Input stalls
// only while a verdict waits in the result register and the sink is not ready.
`default_nettype none

module nmea_sentence_checker #(
    parameter int MAX_LINE_COUNT = 1023
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] rx_byte
    input  wire logic [nsc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [0] sentence_valid, [8:1] computed_checksum, [18:9] line_length,
    // [19] has_star, [20] starts_with_dollar, [23:21] zero
    output logic [nsc_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int CNT_W = $clog2(MAX_LINE_COUNT + 1);
    localparam int VERDICT_W = $bits(nsc_pkg::t_verdict);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_out_valid;
    nsc_pkg::t_verdict          r_out_data;

    logic                       out_free;
    logic                       advance;
    logic                       emit;
    nsc_pkg::t_line_state       line_state;
    logic [CNT_W-1:0]           line_count;
    nsc_pkg::t_verdict          verdict;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    nsc_line_tracker #(
        .MAX_LINE_COUNT (MAX_LINE_COUNT),
        .CNT_W          (CNT_W)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_state (line_state),
        .o_count (line_count),
        .o_emit  (emit)
    );

    nsc_verdict #(
        .CNT_W (CNT_W)
    ) u_verdict (
        .i_state   (line_state),
        .i_count   (line_count),
        .o_verdict (verdict)
    );

    // Hold the verdict until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(nsc_pkg::OUT_DATA_W - VERDICT_W){1'b0}}, r_out_data};

endmodule

`default_nettype wire

[rtl/nsc_checker.sv]
// Port-level assertions for the NMEA sentence checker, bound to the top level.
`default_nettype none

module nsc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [nsc_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // Drop any result after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A valid sentence starts with dollar and carries a star
    a_valid_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[20] && o_m_tdata[19])
        else $error("valid verdict without dollar or star");

    // A line without a star reports a zero checksum
    a_no_star_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[19] |-> o_m_tdata[8:1] == 8'h00)
        else $error("checksum nonzero on a line without star");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

[tb/tb_nmea_sentence_checker.sv]
// Self-checking testbench for the NMEA sentence checker: byte stream in, line verdicts out.
`default_nettype none

module tb_nmea_sentence_checker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_COUNT_MAX = 1023;
    localparam int SETTLE_CYCLES  = 20;

    // Flow-control modes, one per phase
    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow_mode;

    // Kinds of generated lines, picked by percentage bands
    localparam int KIND_NOISE_END    = 12;
    localparam int KIND_NO_DOLLAR    = 17;
    localparam int KIND_SHORT        = 22;
    localparam int KIND_NO_STAR      = 27;
    localparam int KIND_BAD_SUM      = 37;
    localparam int KIND_NON_HEX      = 42;
    localparam int KIND_ONE_SUM_CHAR = 45;
    localparam int KIND_GOOD         = 99;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [nsc_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;     // [7:0] rx_byte
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    // [0] sentence_valid, [8:1] computed_checksum, [18:9] line_length,
    // [19] has_star, [20] starts_with_dollar, [23:21] zero
    logic [nsc_pkg::OUT_DATA_W-1:0] o_m_tdata;

    nmea_sentence_checker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Bytes waiting to be sent and verdicts waiting to arrive
    logic [7:0]        rx_pending[$];
    nsc_pkg::t_verdict verdicts_due[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  byte_taken     = 1'b0;
    int  error_count    = 0;
    int  bytes_queued   = 0;
    int  verdicts_seen  = 0;
    int  valid_seen     = 0;

    // Line tracker state of the predictor
    logic [7:0] line_xor;
    logic [7:0] star_xor;
    logic       star_found;
    logic [1:0] after_star_cnt;
    logic [7:0] sum_hi_char;
    logic [7:0] sum_lo_char;
    logic       dollar_first;
    int         line_chars;
    logic       cr_pending;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return 16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 10) return 8'(nib) + "0";
        return 8'(nib - 10) + (upper ? "A" : "a");
    endfunction

    task automatic clear_line();
        line_xor       = '0;
        star_xor       = '0;
        star_found     = 1'b0;
        after_star_cnt = '0;
        sum_hi_char    = '0;
        sum_lo_char    = '0;
        dollar_first   = 1'b0;
        line_chars     = 0;
        cr_pending     = 1'b0;
    endtask

    // Fold one data character into the line state
    task automatic fold_char(input logic [7:0] c);
        if (line_chars == 0) dollar_first = (c == nsc_pkg::CHAR_DOLLAR);
        if (c == nsc_pkg::CHAR_STAR) begin
            star_found     = 1'b1;
            star_xor       = line_xor;
            after_star_cnt = '0;
        end else if (star_found && after_star_cnt < 2) begin
            if (after_star_cnt == 0) sum_hi_char = c;
            else sum_lo_char = c;
            after_star_cnt++;
        end
        if (line_chars != 0) line_xor ^= c;
        if (line_chars < LINE_COUNT_MAX) line_chars++;
    endtask

    // Advance the predictor by one accepted byte; a line feed closes the line
    task automatic track_byte(input logic [7:0] b);
        nsc_pkg::t_verdict v;
        logic [7:0]        sum;
        if (b == nsc_pkg::CHAR_LF) begin
            if (line_chars != 0) begin
                sum = star_found ? star_xor : 8'h00;
                v.sentence_valid = line_chars >= nsc_pkg::MIN_LINE_LEN && dollar_first &&
                                   star_found && after_star_cnt >= 2 &&
                                   hex_nibble(sum_hi_char) == int'(sum[7:4]) &&
                                   hex_nibble(sum_lo_char) == int'(sum[3:0]);
                v.computed_checksum  = sum;
                v.line_length        = nsc_pkg::LINE_LEN_W'(line_chars);
                v.has_star           = star_found;
                v.starts_with_dollar = dollar_first;
                verdicts_due.push_back(v);
            end
            clear_line();
        end else begin
            if (cr_pending) begin
                fold_char(nsc_pkg::CHAR_CR);
                cr_pending = 1'b0;
            end
            if (b == nsc_pkg::CHAR_CR) cr_pending = 1'b1;
            else fold_char(b);
        end
    endtask

    task automatic check_verdict(input logic [nsc_pkg::OUT_DATA_W-1:0] raw,
                                 input nsc_pkg::t_verdict want);
        nsc_pkg::t_verdict got;
        got = nsc_pkg::t_verdict'(raw[nsc_pkg::LINE_LEN_W+10:0]);
        if (raw[nsc_pkg::OUT_DATA_W-1:nsc_pkg::LINE_LEN_W+11] != '0)
            flag_error($sformatf("pad bits nonzero: %h", raw));
        if (got.sentence_valid != want.sentence_valid)
            flag_error($sformatf("sentence_valid got %0b want %0b",
                                 got.sentence_valid, want.sentence_valid));
        if (got.computed_checksum != want.computed_checksum)
            flag_error($sformatf("computed_checksum got %h want %h",
                                 got.computed_checksum, want.computed_checksum));
        if (got.line_length != want.line_length)
            flag_error($sformatf("line_length got %0d want %0d",
                                 got.line_length, want.line_length));
        if (got.has_star != want.has_star)
            flag_error($sformatf("has_star got %0b want %0b", got.has_star, want.has_star));
        if (got.starts_with_dollar != want.starts_with_dollar)
            flag_error($sformatf("starts_with_dollar got %0b want %0b",
                                 got.starts_with_dollar, want.starts_with_dollar));
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    flag_error($sformatf("unexpected verdict item %h", o_m_tdata));
                end else begin
                    check_verdict(o_m_tdata, verdicts_due[0]);
                    if (verdicts_due[0].sentence_valid) valid_seen++;
                    verdicts_due.delete(0);
                    verdicts_seen++;
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                byte_taken = 1'b1;
                track_byte(i_s_tdata);
                rx_pending.delete(0);
            end
        end
    end

    // Drive the byte stream and the sink ready at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || byte_taken) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= rx_pending[0];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        byte_taken = 1'b0;
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i]) push_byte(s[i]);
    endtask

    task automatic end_line(input int cr_count);
        repeat (cr_count) push_byte(nsc_pkg::CHAR_CR);
        push_byte(nsc_pkg::CHAR_LF);
    endtask

    function automatic logic [7:0] printable_char(input bit allow_star);
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == nsc_pkg::CHAR_STAR && !allow_star) c = "A";
        return c;
    endfunction

    // Queue one line of a kind; payload_len sizes the payload unless noise or short
    task automatic push_line(input int kind, input int payload_len);
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] hi;
        logic [7:0] lo;
        int         crs;
        sum = '0;
        crs = ($urandom_range(0, 99) < 70) ? 1 : 0;
        if ($urandom_range(0, 99) < 5) crs = 2;
        if (kind < KIND_NOISE_END) begin
            // raw bytes of any value, stray feeds and returns included
            repeat ($urandom_range(1, 14)) push_byte(8'($urandom_range(0, 255)));
            end_line(crs);
            return;
        end
        if (kind < KIND_NO_DOLLAR) begin
            c = ($urandom_range(0, 1) != 0) ? nsc_pkg::CHAR_STAR : printable_char(1'b0);
            push_byte(c);
        end else begin
            push_byte(nsc_pkg::CHAR_DOLLAR);
        end
        if (kind >= KIND_NO_DOLLAR && kind < KIND_SHORT) payload_len = $urandom_range(0, 3);
        repeat (payload_len) begin
            c = printable_char($urandom_range(0, 99) < 8);
            push_byte(c);
            sum ^= c;
        end
        if (kind >= KIND_NO_STAR - 5 && kind < KIND_NO_STAR) begin
            end_line(crs);
            return;
        end
        push_byte(nsc_pkg::CHAR_STAR);
        if (kind >= KIND_NO_STAR && kind < KIND_BAD_SUM)
            sum ^= 8'(1 << $urandom_range(0, 7));
        hi = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
        if (kind >= KIND_BAD_SUM && kind < KIND_NON_HEX) begin
            if ($urandom_range(0, 1) != 0) hi = "G";
            else lo = "z";
        end
        push_byte(hi);
        if (kind < KIND_NON_HEX || kind >= KIND_ONE_SUM_CHAR) push_byte(lo);
        if ($urandom_range(0, 99) < 20) push_text(",X");
        end_line(crs);
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_flow(input t_flow_mode mode);
        case (mode)
            FLOW_FREE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            FLOW_SEND_GAPS: begin
                send_idle_pct  = 59;
                recv_stall_pct = 0;
            end
            FLOW_SINK_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct = 59;
            end
            default: begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase
    endtask

    // Fill the byte queue phase by phase and finish the run
    initial begin
        int target;
        clear_line();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: lone feeds, lowercase checksum, leading star with
        // repeated returns, extreme byte values, non-hex checksum
        set_flow(FLOW_FREE);
        push_byte(nsc_pkg::CHAR_LF);
        end_line(1);
        push_text("$ABI*4a");
        end_line(1);
        push_byte(nsc_pkg::CHAR_STAR);
        push_byte(nsc_pkg::CHAR_CR);
        end_line(1);
        push_byte(8'hFF);
        push_byte(8'h00);
        end_line(0);
        push_text("$A*zz");
        end_line(0);

        for (int ph = 0; ph < 4; ph++) begin
            // hold off the sender until every verdict so far has arrived
            wait_drained();
            set_flow(t_flow_mode'(ph));
            target = bytes_queued + 212;
            while (bytes_queued < target) begin
                push_line($urandom_range(0, KIND_GOOD), $urandom_range(3, 20));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes under four flow-control modes; checked %0d verdicts, %0d valid,",
                 bytes_queued, verdicts_seen, valid_seen);
        $display("covering bad checksums, missing fields, stray returns and raw noise lines.");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #3_000_000;
        $display("Timeout with %0d bytes and %0d verdicts outstanding",
                 rx_pending.size(), verdicts_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
